// ----- rtl/tick_task_scheduler_assert.svh -----
// Assertion macros for the tick task scheduler
`ifndef TICK_TASK_SCHEDULER_ASSERT_SVH
`define TICK_TASK_SCHEDULER_ASSERT_SVH

// Property checked at every clock edge outside reset
`define TTS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tick_task_scheduler assertion failed");

// Same, also checked while reset is high
`define TTS_ASSERT_ANY(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("tick_task_scheduler assertion failed");

`endif

// ----- rtl/tts_pkg.sv -----
// Shared types and constants of the tick task scheduler
package tts_pkg;
   localparam int TASK_SLOTS = 16;
   localparam int CALL_DEPTH = 16;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int CNT_W      = $clog2(CALL_DEPTH + 1);

   localparam logic [7:0] DONE_REMOVE   = 8'd254;
   localparam logic [7:0] DONE_FINISHED = 8'd255;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_MISS  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_REM_SLOT  = 3'd2,
      CMD_SET_STATE = 3'd3,
      CMD_DISPATCH  = 3'd4,
      CMD_CLEAR     = 3'd5,
      CMD_REM_ID    = 3'd6,
      CMD_NOP       = 3'd7
   } tts_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DISP,
      ST_RESP
   } tts_state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } tts_fifo_ctrl_type;
endpackage

// ----- rtl/tts_due_fifo.sv -----
// Queue of due slot numbers; pushes drop when full, pops shift toward the head
module tts_due_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  tts_pkg::tts_fifo_ctrl_type ctrl,
   input  logic [tts_pkg::SLOT_W-1:0] push_slot,
   output logic [tts_pkg::SLOT_W-1:0] head_slot,
   output logic [tts_pkg::CNT_W-1:0]  count
);
   import tts_pkg::*;

   localparam int IDX_W = $clog2(CALL_DEPTH);

   logic [SLOT_W-1:0] entry_ff [CALL_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push && (int'(count_ff) < CALL_DEPTH)) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctrl.clear && ctrl.push && (int'(count_ff) < CALL_DEPTH)) begin
         entry_ff[count_ff[IDX_W-1:0]] <= push_slot;
      end else if (!ctrl.clear && ctrl.pop) begin
         for (int j = 0; j < CALL_DEPTH - 1; j++) begin
            entry_ff[j] <= entry_ff[j + 1];
         end
      end
   end

   assign head_slot = entry_ff[0];
   assign count     = count_ff;
endmodule

// ----- rtl/tick_task_scheduler.sv -----
// Tick, add and remove id walk the slot table one slot a cycle; tick walks to the last slot,
// add and remove id stop at a hit. Dispatch passes through a dispatch state when the queue
// is not empty. One transaction at a time; the single slot walker sets throughput.
// Reset (synchronous, active high) empties the table and queue, zeroes uptime and sets the
// active state code to 1, all in the reset cycle.
module tick_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // active_state_code
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0], task_id[10:3], repeat_mode[11], period[27:12],
   // state_value[35:28], slot[39:36]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], slot_out[5:2], task_out[13:6], pending_calls[18:14],
   // uptime[82:19], zero fill[87:83]
   output logic [87:0] rsp_tdata
);
   import tts_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

   tts_state_type state_ff, state_in;

   logic [7:0]  act_ff;
   logic [7:0]  task_ff   [TASK_SLOTS];
   logic [15:0] delay_ff  [TASK_SLOTS];
   logic [15:0] reload_ff [TASK_SLOTS];
   logic [7:0]  sstate_ff [TASK_SLOTS];

   tts_cmd_type       cmd_ff;
   logic [7:0]        id_ff;
   logic              rep_ff;
   logic [15:0]       per_ff;   // period minus one, zero period taken as one
   logic [7:0]        sv_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [1:0]        status_ff;
   logic [SLOT_W-1:0] slot_o_ff;
   logic [7:0]        task_o_ff;
   logic [63:0]       uptime_ff;

   tts_cmd_type       req_cmd;
   logic [15:0]       req_per;
   logic [3:0]        req_slot;
   logic              req_acc;
   logic              rsp_acc;

   logic [7:0]        cur_task;
   logic [15:0]       cur_delay;
   logic [15:0]       cur_reload;
   logic [7:0]        cur_state;
   logic              walk_hit;
   logic              tick_due;
   logic              rm_en;
   logic [SLOT_W-1:0] rm_pos;

   tts_fifo_ctrl_type fifo_ctrl;
   logic [SLOT_W-1:0] fifo_head;
   logic [CNT_W-1:0]  fifo_count;

   assign req_cmd  = tts_cmd_type'(req_tdata[2:0]);
   assign req_per  = req_tdata[27:12];
   assign req_slot = req_tdata[39:36];
   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;

   assign cur_task   = task_ff[idx_ff];
   assign cur_delay  = delay_ff[idx_ff];
   assign cur_reload = reload_ff[idx_ff];
   assign cur_state  = sstate_ff[idx_ff];

   // per-slot decision of the walker
   always_comb begin
      walk_hit = 1'b0;
      tick_due = (cur_task != 8'd0) && (cur_state == act_ff) && (cur_delay == 16'd0);
      case (cmd_ff)
         CMD_ADD:    walk_hit = (cur_task == id_ff) || (cur_task == 8'd0);
         CMD_REM_ID: walk_hit = (cur_task == id_ff);
         default:    walk_hit = 1'b0;
      endcase
   end

   always_comb begin
      rm_en  = 1'b0;
      rm_pos = idx_ff;
      if ((state_ff == ST_IDLE) && req_acc && (req_cmd == CMD_REM_SLOT)
          && (int'(req_slot) < TASK_SLOTS)) begin
         rm_en  = 1'b1;
         rm_pos = SLOT_W'(req_slot);
      end else if ((state_ff == ST_WALK) && (cmd_ff == CMD_REM_ID) && walk_hit) begin
         rm_en = 1'b1;
      end else if ((state_ff == ST_DISP) && (cur_state == DONE_REMOVE)) begin
         rm_en = 1'b1;
      end
   end

   always_comb begin
      fifo_ctrl.push  = (state_ff == ST_WALK) && (cmd_ff == CMD_TICK) && tick_due;
      fifo_ctrl.pop   = (state_ff == ST_DISP);
      fifo_ctrl.clear = (state_ff == ST_IDLE) && req_acc && (req_cmd == CMD_CLEAR);
   end

   tts_due_fifo u_due_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_slot (idx_ff),
      .head_slot (fifo_head),
      .count     (fifo_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  CMD_TICK, CMD_ADD, CMD_REM_ID: state_in = ST_WALK;
                  CMD_DISPATCH: state_in = (fifo_count != '0) ? ST_DISP : ST_RESP;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_hit || (idx_ff == LAST_SLOT)) begin
               state_in = ST_RESP;
            end
         end
         ST_DISP: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 8'd1;
      end else if (csr_wr_en) begin
         act_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff <= '0;
      end else if ((state_ff == ST_WALK) && (cmd_ff == CMD_TICK) && (idx_ff == LAST_SLOT)) begin
         uptime_ff <= uptime_ff + 64'd1;
      end
   end

   // transaction fields and result
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_ff    <= req_cmd;
               id_ff     <= req_tdata[10:3];
               rep_ff    <= req_tdata[11];
               per_ff    <= (req_per == 16'd0) ? 16'd0 : req_per - 16'd1;
               sv_ff     <= req_tdata[35:28];
               idx_ff    <= (req_cmd == CMD_DISPATCH) ? fifo_head : '0;
               slot_o_ff <= '0;
               task_o_ff <= 8'd0;
               if ((req_cmd == CMD_ADD) || (req_cmd == CMD_REM_ID)) begin
                  status_ff <= STATUS_MISS;
               end else if ((req_cmd == CMD_DISPATCH) && (fifo_count == '0)) begin
                  status_ff <= STATUS_EMPTY;
               end else begin
                  status_ff <= STATUS_OK;
               end
            end
         end
         ST_WALK: begin
            if (walk_hit) begin
               status_ff <= STATUS_OK;
               if (cmd_ff == CMD_ADD) begin
                  slot_o_ff <= idx_ff;
               end
            end
            if (idx_ff != LAST_SLOT) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_DISP: begin
            slot_o_ff <= idx_ff;
            task_o_ff <= cur_task;
         end
         default: begin
         end
      endcase
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TASK_SLOTS; j++) begin
            task_ff[j]   <= 8'd0;
            delay_ff[j]  <= 16'd0;
            reload_ff[j] <= 16'd0;
            sstate_ff[j] <= 8'd1;
         end
      end else if (fifo_ctrl.clear) begin
         for (int j = 0; j < TASK_SLOTS; j++) begin
            task_ff[j]   <= 8'd0;
            delay_ff[j]  <= 16'd0;
            reload_ff[j] <= 16'd0;
            sstate_ff[j] <= act_ff;
         end
      end else if (rm_en) begin
         // compact toward slot 0
         for (int j = 0; j < TASK_SLOTS - 1; j++) begin
            if (j >= int'(rm_pos)) begin
               task_ff[j]   <= task_ff[j + 1];
               delay_ff[j]  <= delay_ff[j + 1];
               reload_ff[j] <= reload_ff[j + 1];
               sstate_ff[j] <= sstate_ff[j + 1];
            end
         end
         task_ff[TASK_SLOTS - 1]   <= 8'd0;
         delay_ff[TASK_SLOTS - 1]  <= 16'd0;
         reload_ff[TASK_SLOTS - 1] <= 16'd0;
         sstate_ff[TASK_SLOTS - 1] <= act_ff;
      end else if ((state_ff == ST_IDLE) && req_acc && (req_cmd == CMD_SET_STATE)
                   && (int'(req_slot) < TASK_SLOTS)) begin
         sstate_ff[SLOT_W'(req_slot)] <= req_tdata[35:28];
      end else if (state_ff == ST_WALK) begin
         if ((cmd_ff == CMD_ADD) && walk_hit) begin
            task_ff[idx_ff]   <= id_ff;
            delay_ff[idx_ff]  <= per_ff;
            reload_ff[idx_ff] <= rep_ff ? per_ff : 16'd0;
            sstate_ff[idx_ff] <= sv_ff;
         end else if ((cmd_ff == CMD_TICK) && (cur_task != 8'd0) && (cur_state == act_ff)) begin
            if (!tick_due) begin
               delay_ff[idx_ff] <= cur_delay - 16'd1;
            end else if (cur_reload == 16'd0) begin
               sstate_ff[idx_ff] <= DONE_FINISHED;
            end else begin
               delay_ff[idx_ff] <= cur_reload;
            end
         end
      end
   end

   assign rsp_tdata = {5'd0, uptime_ff, 5'(fifo_count), task_o_ff, 4'(slot_o_ff), status_ff};

`include "tick_task_scheduler_assert.svh"

   `TTS_ASSERT(a_queue_bound, int'(fifo_count) <= CALL_DEPTH)
   `TTS_ASSERT(a_walk_ends, (state_ff == ST_WALK) && (idx_ff == LAST_SLOT) |=> (state_ff == ST_RESP))
   `TTS_ASSERT(a_uptime_tick, (uptime_ff != $past(uptime_ff)) |-> ($past(cmd_ff) == CMD_TICK))
   `TTS_ASSERT(a_one_side, !(req_tready && rsp_tvalid))
endmodule

// ----- tb/tick_task_scheduler_tb.sv -----
// Testbench for the tick task scheduler: model-based scoreboard with directed and random stimulus
`timescale 1ns / 100ps

import tts_pkg::*;

typedef struct packed {
   logic [1:0]  status;
   logic [3:0]  slot_out;
   logic [7:0]  task_out;
   logic [4:0]  pending_calls;
   logic [63:0] uptime;
} sched_result_type;

class sched_scoreboard;
   logic [7:0]  active_code;
   logic [7:0]  task_id_tab [TASK_SLOTS];
   logic [15:0] delay_tab [TASK_SLOTS];
   logic [15:0] reload_tab [TASK_SLOTS];
   logic [7:0]  state_tab [TASK_SLOTS];
   logic [3:0]  due_q [$];
   logic [63:0] ticks;
   sched_result_type pending_results [$];
   int errors;
   int checked;

   function void reset_model();
      active_code = 8'd1;
      ticks = '0;
      clear_table();
   endfunction

   function void clear_slot(int s);
      task_id_tab[s] = '0;
      delay_tab[s] = '0;
      reload_tab[s] = '0;
      state_tab[s] = active_code;
   endfunction

   function void clear_table();
      for (int i = 0; i < TASK_SLOTS; i++) clear_slot(i);
      due_q.delete();
   endfunction

   function void compact(int s);
      for (int j = s; j + 1 < TASK_SLOTS; j++) begin
         task_id_tab[j] = task_id_tab[j+1];
         delay_tab[j] = delay_tab[j+1];
         reload_tab[j] = reload_tab[j+1];
         state_tab[j] = state_tab[j+1];
      end
      clear_slot(TASK_SLOTS - 1);
   endfunction

   // note an accepted request and queue its expected response
   function void note_request(logic [39:0] d);
      tts_cmd_type cmd;
      logic [7:0]  id;
      logic        rep;
      logic [15:0] per;
      logic [7:0]  sv;
      logic [3:0]  sl;
      sched_result_type r;
      cmd = tts_cmd_type'(d[2:0]);
      id = d[10:3];
      rep = d[11];
      per = d[27:12];
      sv = d[35:28];
      sl = d[39:36];
      r = '0;
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (task_id_tab[i] != 0 && state_tab[i] == active_code) begin
                  if (delay_tab[i] != 0) delay_tab[i]--;
                  else begin
                     if (due_q.size() < CALL_DEPTH) due_q.push_back(4'(i));
                     if (reload_tab[i] == 0) state_tab[i] = DONE_FINISHED;
                     else delay_tab[i] = reload_tab[i];
                  end
               end
            end
            ticks++;
         end
         CMD_ADD: begin
            if (per == 0) per = 1;
            r.status = STATUS_MISS;
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (task_id_tab[i] == id || task_id_tab[i] == 0) begin
                  task_id_tab[i] = id;
                  delay_tab[i] = per - 1;
                  reload_tab[i] = rep ? per - 1 : 16'd0;
                  state_tab[i] = sv;
                  r.slot_out = 4'(i);
                  r.status = STATUS_OK;
                  break;
               end
            end
         end
         CMD_REM_SLOT: compact(sl);
         CMD_SET_STATE: state_tab[sl] = sv;
         CMD_DISPATCH: begin
            if (due_q.size() == 0) r.status = STATUS_EMPTY;
            else begin
               logic [3:0] s;
               s = due_q.pop_front();
               r.slot_out = s;
               r.task_out = task_id_tab[s];
               if (state_tab[s] == DONE_REMOVE) compact(s);
            end
         end
         CMD_CLEAR: clear_table();
         CMD_REM_ID: begin
            r.status = STATUS_MISS;
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (task_id_tab[i] == id) begin
                  compact(i);
                  r.status = STATUS_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.pending_calls = 5'(due_q.size());
      r.uptime = ticks;
      pending_results.push_back(r);
   endfunction

   function void check_response(logic [87:0] d);
      sched_result_type e;
      if (pending_results.size() == 0) begin
         $error("response with no transaction outstanding");
         errors++;
         return;
      end
      e = pending_results.pop_front();
      checked++;
      if (d[1:0] != e.status) begin
         $error("status exp %0d got %0d", e.status, d[1:0]); errors++;
      end
      if (d[5:2] != e.slot_out) begin
         $error("slot_out exp %0d got %0d", e.slot_out, d[5:2]); errors++;
      end
      if (d[13:6] != e.task_out) begin
         $error("task_out exp %0d got %0d", e.task_out, d[13:6]); errors++;
      end
      if (d[18:14] != e.pending_calls) begin
         $error("pending_calls exp %0d got %0d", e.pending_calls, d[18:14]); errors++;
      end
      if (d[82:19] != e.uptime) begin
         $error("uptime exp %0d got %0d", e.uptime, d[82:19]); errors++;
      end
   endfunction
endclass

module tick_task_scheduler_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [7:0]  csr_wr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent = 0;
   sched_scoreboard board;

   always #1 clock = ~clock;

   tick_task_scheduler i_dut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // leaves req_tvalid high on return; the caller sends again or drops it
   task automatic send(tts_cmd_type cmd, logic [7:0] id, logic rep, logic [15:0] per,
                       logic [7:0] sv, logic [3:0] sl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {sl, sv, per, rep, id, 3'(cmd)};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_code(logic [7:0] v);
      req_tvalid <= 0;
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      csr_wr_data <= v;
      csr_wr_en <= 1;
      @(negedge clock);
      csr_wr_en <= 0;
      board.active_code = v;
   endtask

   task automatic random_item();
      int k;
      logic [7:0] id;
      k = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 20));
      if (k < 35)
         send(CMD_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
      else if (k < 55)
         send(CMD_ADD, id, 1'($urandom),
              ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5)),
              ($urandom_range(3) == 0) ? 8'($urandom) :
              ($urandom_range(1) ? board.active_code : DONE_REMOVE),
              4'($urandom));
      else if (k < 75)
         send(CMD_DISPATCH, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom));
      else if (k < 82)
         send(CMD_SET_STATE, 8'($urandom), 1'($urandom), 16'($urandom),
              $urandom_range(1) ? DONE_REMOVE : 8'($urandom), 4'($urandom));
      else if (k < 88)
         send(CMD_REM_SLOT, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom));
      else if (k < 96)
         send(CMD_REM_ID, id, 1'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
      else if (k < 98)
         send(CMD_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom));
      else
         send(CMD_NOP, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom));
   endtask

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [7:0] codes [4];
      board = new();
      board.reset_model();
      repeat (6) @(negedge clock);
      reset <= 0;

      // directed: extremes, every command, full table, one-shot tasks
      send(CMD_DISPATCH, 8'h00, 0, 16'h0000, 8'h00, 4'h0);
      send(CMD_ADD, 8'hFF, 1, 16'h0000, 8'd1, 4'hF);
      send(CMD_ADD, 8'h00, 0, 16'hFFFF, 8'd1, 4'h0);
      send(CMD_ADD, 8'h05, 0, 16'h0002, 8'd1, 4'h0);
      send(CMD_ADD, 8'h06, 1, 16'h0001, DONE_REMOVE, 4'h0);
      for (int i = 0; i < 14; i++) send(CMD_ADD, 8'(10 + i), 1, 16'h0001, 8'd1, 4'h0);
      send(CMD_ADD, 8'hAA, 1, 16'h0001, 8'd1, 4'h0);
      send(CMD_TICK, 8'hFF, 1, 16'hFFFF, 8'hFF, 4'hF);
      send(CMD_TICK, 8'h00, 0, 16'h0000, 8'h00, 4'h0);
      send(CMD_SET_STATE, 8'h00, 0, 16'h0, DONE_REMOVE, 4'hF);
      send(CMD_DISPATCH, 8'h00, 0, 16'h0, 8'h00, 4'h0);
      send(CMD_REM_SLOT, 8'h00, 0, 16'h0, 8'h00, 4'hF);
      send(CMD_REM_ID, 8'h00, 0, 16'h0, 8'h00, 4'h0);
      send(CMD_REM_ID, 8'hEE, 0, 16'h0, 8'h00, 4'h0);
      send(CMD_NOP, 8'hFF, 1, 16'hFFFF, 8'hFF, 4'hF);
      send(CMD_CLEAR, 8'h00, 0, 16'h0, 8'h00, 4'h0);

      codes = '{8'd0, 8'd253, 8'd7, 8'd1};
      for (int ph = 0; ph < 4; ph++) begin
         write_code(codes[ph]);
         send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 56 : 0;
         recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 36 : 0;
         for (int n = 0; n < 385; n++) random_item();
      end
      req_tvalid <= 0;

      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("Ran %0d transactions, %0d responses checked, over four state codes", sent,
               board.checked);
      if (board.errors == 0 && board.pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_due_fifo.sv
rtl/tick_task_scheduler.sv
tb/tick_task_scheduler_tb.sv
